// ===== hdl/lsps_pkg.sv =====
package lsps_pkg;

    localparam int PIXEL_W    = 24;
    localparam int COUNT_W    = 9;
    localparam int TICK_W     = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] FUNC_WRITE   = 3'd0;
    localparam logic [2:0] FUNC_FILL    = 3'd1;
    localparam logic [2:0] FUNC_SCALE   = 3'd2;
    localparam logic [2:0] FUNC_REFRESH = 3'd3;
    localparam logic [2:0] FUNC_TICK    = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_BUSY  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_HIGH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LOW    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_HIGH    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_LOW     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_LATCH       = 3'd5;

    localparam logic [COUNT_W-1:0] RST_PIXEL_COUNT = 9'd1;
    localparam logic [7:0]         RST_ZERO_HIGH   = 8'd3;
    localparam logic [7:0]         RST_ZERO_LOW    = 8'd9;
    localparam logic [7:0]         RST_ONE_HIGH    = 8'd9;
    localparam logic [7:0]         RST_ONE_LOW     = 8'd3;
    localparam logic [15:0]        RST_LATCH       = 16'd250;

    localparam logic [4:0] BIT_LAST  = 5'd23;
    localparam logic [4:0] BITS_PIX  = 5'd24;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] brightness;
    } t_in_item;

    typedef struct packed {
        logic       line_level;
        logic       sending;
        logic       frame_done;
        logic [1:0] status;
    } t_out_item;

    // floor(c*b/255) for a 16-bit product
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] b);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = c * b;
        sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

    function automatic logic [PIXEL_W-1:0] scale_word(input logic [PIXEL_W-1:0] w,
                                                      input logic [7:0] b);
        return {scale8(w[23:16], b), scale8(w[15:8], b), scale8(w[7:0], b)};
    endfunction

endpackage

// ===== hdl/lsps_ram.sv =====
module lsps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/led_strip_pixel_serializer_top.sv =====
// One-wire LED strip serializer with a pixel store.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries host commands:
// write pixel, fill, scale all, start refresh and line tick. Output channel
// (o_out_valid / i_out_stall / o_out_data) returns exactly one result per
// command: line level for a tick, sending flag, frame done and status.
// Write, refresh, tick and unused codes: the accept cycle reads the current
// pixel from the store RAM, then the execute state applies the command and
// loads the output register once it is free. Fill and scale sweep the store
// over pixel_count entries (at most MAX_PIXELS), one store entry per cycle
// through the single RAM write port. One command is in flight at a time.
// Results are in order; while the receiver stalls, the output register holds
// its result, one more command is accepted and waits until that register
// frees up. Configuration writes (i_cfg_wr_en / i_cfg_addr / i_cfg_data)
// must come only while no command is pending; the block does not check.
// Synchronous reset restores register defaults, an idle line and a cleared
// store (per-entry valid bits, no clearing pass); the block takes commands
// in the first cycle after reset.
module led_strip_pixel_serializer_top #(
    parameter int MAX_PIXELS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lsps_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lsps_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [lsps_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FILL, S_SCALE} t_state;
    typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_GAP} t_phase;

    t_state                           r_state;
    lsps_pkg::t_in_item               r_item;
    t_phase                           r_phase,   n_phase;
    logic [7:0]                       r_pix_ptr, n_pix_ptr;
    logic [4:0]                       r_bit_ptr, n_bit_ptr;
    logic                             r_half,    n_half;
    logic [lsps_pkg::TICK_W-1:0]      r_tick,    n_tick;
    lsps_pkg::t_out_item              n_res;

    logic [lsps_pkg::COUNT_W-1:0]     r_pixel_count;
    logic [7:0]                       r_zero_high, r_zero_low, r_one_high, r_one_low;
    logic [15:0]                      r_latch;

    logic [MAX_PIXELS-1:0]            r_valid;
    logic                             r_rd_vld;
    logic [lsps_pkg::COUNT_W-1:0]     r_sw_idx;
    logic                             r_sw_pend;
    logic [ADDR_W-1:0]                r_sw_wr;

    logic                             r_out_valid;
    lsps_pkg::t_out_item              r_out;

    logic                             in_accept, out_free;
    logic [lsps_pkg::COUNT_W-1:0]     eff_count;
    logic                             idx_bad, ptr_in_range, sweep_live;

    logic                             ram_rd_en, ram_wr_en, rd_in_range;
    logic [ADDR_W-1:0]                ram_rd_addr, ram_wr_addr;
    logic [lsps_pkg::PIXEL_W-1:0]     ram_wr_data, ram_rd_data, rd_word, in_color;

    logic [4:0]                       bp_mod, bit_idx;
    logic                             data_bit;
    logic [7:0]                       pulse_len, pulse_len1;
    logic [15:0]                      latch1;
    logic [lsps_pkg::TICK_W-1:0]      tick_inc, gap_len;
    logic [lsps_pkg::COUNT_W-1:0]     ptr_next;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign eff_count    = (32'(r_pixel_count) > MAX_PIXELS) ?
                          lsps_pkg::COUNT_W'(MAX_PIXELS) : r_pixel_count;
    assign idx_bad      = ({1'b0, r_item.pixel_index} >= eff_count) ||
                          (32'(r_item.pixel_index) >= MAX_PIXELS);
    assign ptr_in_range = (32'(r_pix_ptr) < MAX_PIXELS);
    assign sweep_live   = (r_sw_idx < eff_count);
    assign in_color     = {r_item.green, r_item.red, r_item.blue};
    assign rd_word      = r_rd_vld ? ram_rd_data : '0;

    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(r_pix_ptr);
        rd_in_range = ptr_in_range;
        if (in_accept) begin
            ram_rd_en = 1'b1;
        end
        if (r_state == S_SCALE && sweep_live) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ADDR_W'(r_sw_idx);
            rd_in_range = 1'b1;
        end
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = ADDR_W'(r_item.pixel_index);
        ram_wr_data = lsps_pkg::scale_word(in_color, r_item.brightness);
        unique case (r_state)
            S_EXEC: begin
                ram_wr_en = out_free && (r_item.func == lsps_pkg::FUNC_WRITE) && !idx_bad;
            end
            S_FILL: begin
                ram_wr_en   = sweep_live;
                ram_wr_addr = ADDR_W'(r_sw_idx);
                ram_wr_data = in_color;
            end
            S_SCALE: begin
                ram_wr_en   = r_sw_pend;
                ram_wr_addr = r_sw_wr;
                ram_wr_data = lsps_pkg::scale_word(rd_word, r_item.brightness);
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    lsps_ram #(
        .WIDTH (lsps_pkg::PIXEL_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign bp_mod     = (r_bit_ptr >= lsps_pkg::BITS_PIX) ? r_bit_ptr - lsps_pkg::BITS_PIX
                                                          : r_bit_ptr;
    assign bit_idx    = lsps_pkg::BIT_LAST - bp_mod;
    assign data_bit   = rd_word[bit_idx];
    assign pulse_len  = !r_half ? (data_bit ? r_one_high : r_zero_high)
                                : (data_bit ? r_one_low  : r_zero_low);
    assign pulse_len1 = (pulse_len == 8'd0) ? 8'd1 : pulse_len;
    assign latch1     = (r_latch == 16'd0) ? 16'd1 : r_latch;
    assign gap_len    = {latch1, 1'b0};
    assign tick_inc   = r_tick + 17'd1;
    assign ptr_next   = {1'b0, r_pix_ptr} + 9'd1;

    always_comb begin
        n_phase   = r_phase;
        n_pix_ptr = r_pix_ptr;
        n_bit_ptr = r_bit_ptr;
        n_half    = r_half;
        n_tick    = r_tick;
        n_res     = '0;
        unique case (r_item.func)
            lsps_pkg::FUNC_WRITE: begin
                if (idx_bad) begin
                    n_res.status = lsps_pkg::STATUS_RANGE;
                end
            end
            lsps_pkg::FUNC_REFRESH: begin
                if (r_phase != PH_IDLE) begin
                    n_res.status = lsps_pkg::STATUS_BUSY;
                end else begin
                    n_pix_ptr = '0;
                    n_bit_ptr = '0;
                    n_half    = 1'b0;
                    n_tick    = '0;
                    n_phase   = (eff_count == '0) ? PH_GAP : PH_DATA;
                end
            end
            lsps_pkg::FUNC_TICK: begin
                if (r_phase == PH_DATA) begin
                    n_res.line_level = !r_half;
                    n_tick = tick_inc;
                    if (tick_inc >= 17'(pulse_len1)) begin
                        n_tick = '0;
                        if (!r_half) begin
                            n_half = 1'b1;
                        end else begin
                            n_half = 1'b0;
                            if (r_bit_ptr >= lsps_pkg::BIT_LAST) begin
                                n_bit_ptr = '0;
                                if (ptr_next >= eff_count) begin
                                    n_pix_ptr = '0;
                                    n_phase   = PH_GAP;
                                end else begin
                                    n_pix_ptr = ptr_next[7:0];
                                end
                            end else begin
                                n_bit_ptr = r_bit_ptr + 5'd1;
                            end
                        end
                    end
                end else if (r_phase == PH_GAP) begin
                    n_tick = tick_inc;
                    if (tick_inc >= gap_len) begin
                        n_tick           = '0;
                        n_phase          = PH_IDLE;
                        n_res.frame_done = 1'b1;
                    end
                end
            end
            default: begin
                n_res.status = lsps_pkg::STATUS_OK;
            end
        endcase
        n_res.sending = (r_item.func == lsps_pkg::FUNC_TICK) ? (r_phase != PH_IDLE)
                                                             : (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_IDLE;
            r_pix_ptr     <= '0;
            r_bit_ptr     <= '0;
            r_half        <= 1'b0;
            r_tick        <= '0;
            r_pixel_count <= lsps_pkg::RST_PIXEL_COUNT;
            r_zero_high   <= lsps_pkg::RST_ZERO_HIGH;
            r_zero_low    <= lsps_pkg::RST_ZERO_LOW;
            r_one_high    <= lsps_pkg::RST_ONE_HIGH;
            r_one_low     <= lsps_pkg::RST_ONE_LOW;
            r_latch       <= lsps_pkg::RST_LATCH;
            r_valid       <= '0;
            r_rd_vld      <= 1'b0;
            r_sw_idx      <= '0;
            r_sw_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    lsps_pkg::CFG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[8:0];
                    lsps_pkg::CFG_ZERO_HIGH:   r_zero_high   <= i_cfg_data[7:0];
                    lsps_pkg::CFG_ZERO_LOW:    r_zero_low    <= i_cfg_data[7:0];
                    lsps_pkg::CFG_ONE_HIGH:    r_one_high    <= i_cfg_data[7:0];
                    lsps_pkg::CFG_ONE_LOW:     r_one_low     <= i_cfg_data[7:0];
                    lsps_pkg::CFG_LATCH:       r_latch       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (ram_wr_en) begin
                r_valid[ram_wr_addr] <= 1'b1;
            end
            if (ram_rd_en) begin
                r_rd_vld <= rd_in_range && r_valid[ram_rd_addr];
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_item    <= i_in_data;
                        r_sw_idx  <= '0;
                        r_sw_pend <= 1'b0;
                        if (i_in_data.func == lsps_pkg::FUNC_FILL) begin
                            r_state <= S_FILL;
                        end else if (i_in_data.func == lsps_pkg::FUNC_SCALE) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_FILL: begin
                    if (sweep_live) begin
                        r_sw_idx <= r_sw_idx + 9'd1;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_SCALE: begin
                    if (sweep_live) begin
                        r_sw_idx  <= r_sw_idx + 9'd1;
                        r_sw_pend <= 1'b1;
                        r_sw_wr   <= ADDR_W'(r_sw_idx);
                    end else begin
                        r_sw_pend <= 1'b0;
                        if (!r_sw_pend) begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_phase     <= n_phase;
                        r_pix_ptr   <= n_pix_ptr;
                        r_bit_ptr   <= n_bit_ptr;
                        r_half      <= n_half;
                        r_tick      <= n_tick;
                        r_out       <= n_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pend_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sw_pend |-> r_state == S_SCALE)
        else $error("scale write pending outside the scale sweep");

    a_bit_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_ptr <= lsps_pkg::BIT_LAST)
        else $error("bit pointer past the last bit of a pixel");

    a_done_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |->
            o_out_data.sending && !o_out_data.line_level)
        else $error("frame done without sending or with a high line");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> r_state != S_IDLE)
        else $error("store write with no command in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state != S_IDLE)
        else $error("accepted transfer did not start work");

endmodule

// ===== dv/tb_led_strip_pixel_serializer_top.sv =====
`timescale 1ns / 100ps

module tb_led_strip_pixel_serializer_top;
    import lsps_pkg::*;

    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int STRIP_DEPTH = 256;

    typedef enum logic [1:0] {
        LINE_IDLE,
        LINE_DATA,
        LINE_GAP
    } t_line_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    led_strip_pixel_serializer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [PIXEL_W-1:0] strip_pixels [STRIP_DEPTH];
    t_line_phase        line_phase = LINE_IDLE;
    int unsigned        cur_pixel = 0;
    int unsigned        cur_bit = 0;
    bit                 low_half = 1'b0;
    int unsigned        pulse_ticks = 0;

    logic [COUNT_W-1:0] cfg_count = RST_PIXEL_COUNT;
    logic [7:0]         cfg_zero_high = RST_ZERO_HIGH;
    logic [7:0]         cfg_zero_low = RST_ZERO_LOW;
    logic [7:0]         cfg_one_high = RST_ONE_HIGH;
    logic [7:0]         cfg_one_low = RST_ONE_LOW;
    logic [15:0]        cfg_latch = RST_LATCH;

    t_out_item due_results [$];
    int        bad_results = 0;
    bit        idle_on = 1'b1;

    initial begin
        for (int i = 0; i < STRIP_DEPTH; i++) strip_pixels[i] = '0;
    end

    function automatic int unsigned live_count();
        return (cfg_count > 9'd256) ? 256 : int'(cfg_count);
    endfunction

    function automatic logic [PIXEL_W-1:0] dim_word(input logic [PIXEL_W-1:0] w,
                                                     input logic [7:0] br);
        logic [15:0] pg, pr, pb;
        pg = w[23:16] * br;
        pr = w[15:8] * br;
        pb = w[7:0] * br;
        return {8'(pg / 16'd255), 8'(pr / 16'd255), 8'(pb / 16'd255)};
    endfunction

    function automatic t_out_item predict_strip(input t_in_item it);
        t_out_item          res;
        logic [PIXEL_W-1:0] color;
        logic [PIXEL_W-1:0] word;
        logic               data_bit;
        int unsigned        n;
        int unsigned        len;
        int unsigned        i;
        res = '0;
        n = live_count();
        color = {it.green, it.red, it.blue};
        res.sending = (line_phase != LINE_IDLE);
        case (it.func)
            FUNC_WRITE: begin
                if (it.pixel_index >= n) res.status = STATUS_RANGE;
                else strip_pixels[it.pixel_index] = dim_word(color, it.brightness);
            end
            FUNC_FILL: begin
                for (i = 0; i < n; i++) strip_pixels[i] = color;
            end
            FUNC_SCALE: begin
                for (i = 0; i < n; i++) strip_pixels[i] = dim_word(strip_pixels[i], it.brightness);
            end
            FUNC_REFRESH: begin
                if (line_phase != LINE_IDLE) begin
                    res.status = STATUS_BUSY;
                end else begin
                    cur_pixel = 0;
                    cur_bit = 0;
                    low_half = 1'b0;
                    pulse_ticks = 0;
                    line_phase = (n == 0) ? LINE_GAP : LINE_DATA;
                end
            end
            FUNC_TICK: begin
                if (line_phase == LINE_DATA) begin
                    word = strip_pixels[cur_pixel];
                    data_bit = word[23 - (cur_bit % 24)];
                    if (!low_half) len = data_bit ? cfg_one_high : cfg_zero_high;
                    else len = data_bit ? cfg_one_low : cfg_zero_low;
                    if (len == 0) len = 1;
                    res.line_level = !low_half;
                    pulse_ticks++;
                    if (pulse_ticks >= len) begin
                        pulse_ticks = 0;
                        if (!low_half) begin
                            low_half = 1'b1;
                        end else begin
                            low_half = 1'b0;
                            if (cur_bit >= 23) begin
                                cur_bit = 0;
                                if (cur_pixel + 1 >= n) begin
                                    cur_pixel = 0;
                                    line_phase = LINE_GAP;
                                end else begin
                                    cur_pixel = (cur_pixel + 1) & 8'hff;
                                end
                            end else begin
                                cur_bit++;
                            end
                        end
                    end
                end else if (line_phase == LINE_GAP) begin
                    pulse_ticks++;
                    if (pulse_ticks >= 2 * ((cfg_latch == 0) ? 1 : int'(cfg_latch))) begin
                        pulse_ticks = 0;
                        line_phase = LINE_IDLE;
                        res.frame_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (it.func != FUNC_TICK) res.sending = (line_phase != LINE_IDLE);
        return res;
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // receiver stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_out_item want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (due_results.size() == 0) begin
                    if (bad_results < 10)
                        $display("unexpected result: level %0b sending %0b done %0b status %0d",
                                 o_out_data.line_level, o_out_data.sending,
                                 o_out_data.frame_done, o_out_data.status);
                    bad_results++;
                end else begin
                    want = due_results.pop_front();
                    if (o_out_data.line_level !== want.line_level ||
                        o_out_data.sending !== want.sending ||
                        o_out_data.frame_done !== want.frame_done ||
                        o_out_data.status !== want.status) begin
                        if (bad_results < 10)
                            $display({"mismatch: expected level %0b sending %0b done %0b ",
                                      "status %0d, got level %0b sending %0b done %0b status %0d"},
                                     want.line_level, want.sending, want.frame_done,
                                     want.status, o_out_data.line_level, o_out_data.sending,
                                     o_out_data.frame_done, o_out_data.status);
                        bad_results++;
                    end
                end
            end
        end
    end

    task automatic send_item(input t_in_item it);
        bit taken;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (o_in_stall === 1'b0);
            if (taken) due_results.push_back(predict_strip(it));
            @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input logic [2:0] f, input logic [7:0] idx, r, g, b, br);
        t_in_item it;
        it = '{func: f, pixel_index: idx, red: r, green: g, blue: b, brightness: br};
        send_item(it);
    endtask

    task automatic send_tick();
        send_cmd(FUNC_TICK, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
    endtask

    task automatic run_frame();
        while (line_phase != LINE_IDLE) send_tick();
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_PIXEL_COUNT: cfg_count = data[COUNT_W-1:0];
            CFG_ZERO_HIGH:   cfg_zero_high = data[7:0];
            CFG_ZERO_LOW:    cfg_zero_low = data[7:0];
            CFG_ONE_HIGH:    cfg_one_high = data[7:0];
            CFG_ONE_LOW:     cfg_one_low = data[7:0];
            CFG_LATCH:       cfg_latch = data;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // pad unused upper bits with noise
    task automatic program_timing(input logic [COUNT_W-1:0] count,
                                  input logic [7:0] zh, zl, oh, ol,
                                  input logic [15:0] latch);
        cfg_write(CFG_PIXEL_COUNT, {7'($urandom), count});
        cfg_write(CFG_ZERO_HIGH, {rnd8(), zh});
        cfg_write(CFG_ZERO_LOW, {rnd8(), zl});
        cfg_write(CFG_ONE_HIGH, {rnd8(), oh});
        cfg_write(CFG_ONE_LOW, {rnd8(), ol});
        cfg_write(CFG_LATCH, latch);
    endtask

    task automatic test_default_frame();
        send_cmd(FUNC_WRITE, 8'd0, 8'h0f, 8'hf0, 8'h5a, 8'hff);
        send_cmd(FUNC_WRITE, 8'd1, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_frame();
    endtask

    task automatic test_commands();
        program_timing(9'd4, 8'd1, 8'd2, 8'd2, 8'd1, 16'd2);
        send_cmd(FUNC_WRITE, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(FUNC_WRITE, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_WRITE, 8'd1, 8'h80, 8'h7f, 8'h01, 8'h80);
        send_cmd(FUNC_WRITE, 8'd2, 8'hff, 8'hff, 8'hff, 8'h01);
        send_cmd(FUNC_WRITE, 8'd2, 8'hff, 8'h80, 8'h01, 8'hfe);
        send_cmd(FUNC_WRITE, 8'd4, 8'h12, 8'h34, 8'h56, 8'hff);
        send_cmd(FUNC_WRITE, 8'd255, 8'h12, 8'h34, 8'h56, 8'hff);
        send_cmd(FUNC_FILL, 8'd0, 8'h55, 8'haa, 8'hff, 8'h00);
        send_cmd(FUNC_SCALE, 8'd0, 8'h00, 8'h00, 8'h00, 8'd200);
        send_cmd(FUNC_WRITE, 8'd3, 8'hc3, 8'h3c, 8'ha5, 8'hff);
        send_cmd(FUNC_SCALE, 8'd0, 8'h00, 8'h00, 8'h00, 8'hff);
        send_cmd(FUNC_SPARE_5, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        send_cmd(FUNC_SPARE_6, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        send_cmd(FUNC_SPARE_7, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        send_tick();
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_tick();
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_cmd(FUNC_WRITE, 8'd2, 8'h01, 8'h02, 8'h04, 8'hff);
        run_frame();
        send_cmd(FUNC_FILL, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_frame();
    endtask

    task automatic test_zero_registers();
        program_timing(9'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        cfg_write(CFG_SPARE_6, 16'hffff);
        cfg_write(CFG_SPARE_7, 16'h1234);
        send_cmd(FUNC_WRITE, 8'd0, 8'hff, 8'hff, 8'hff, 8'hff);
        send_cmd(FUNC_FILL, 8'd0, 8'hff, 8'hff, 8'hff, 8'h00);
        send_cmd(FUNC_SCALE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h10);
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_frame();
        cfg_write(CFG_PIXEL_COUNT, 16'd1);
        send_cmd(FUNC_WRITE, 8'd0, 8'ha5, 8'h3c, 8'hc3, 8'hff);
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_frame();
    endtask

    task automatic test_live_changes();
        program_timing(9'd3, 8'd2, 8'd1, 8'd1, 8'd2, 16'd3);
        send_cmd(FUNC_WRITE, 8'd0, 8'hf0, 8'h0f, 8'h99, 8'hff);
        send_cmd(FUNC_WRITE, 8'd1, 8'h66, 8'hcc, 8'h33, 8'hff);
        send_cmd(FUNC_WRITE, 8'd2, 8'hff, 8'h00, 8'hff, 8'hff);
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        repeat (100) send_tick();
        cfg_write(CFG_ZERO_HIGH, 16'd5);
        send_cmd(FUNC_WRITE, 8'd1, 8'h00, 8'hff, 8'h00, 8'hff);
        repeat (20) send_tick();
        cfg_write(CFG_PIXEL_COUNT, 16'd1);
        run_frame();
    endtask

    task automatic test_random_traffic();
        int unsigned n, pick, round, k;
        logic [7:0]  idx, br;
        for (round = 0; round < 8; round++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            program_timing(9'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3)),
                           8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                           8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                           16'($urandom_range(0, 6)));
            for (k = 0; k < 190; k++) begin
                n = live_count();
                pick = $urandom_range(0, 99);
                br = ($urandom_range(0, 3) == 0) ? 8'hff : rnd8();
                idx = ($urandom_range(0, 4) == 0) ? rnd8() : 8'($urandom_range(0, n + 1));
                if (line_phase == LINE_IDLE) begin
                    if (pick < 40) send_cmd(FUNC_WRITE, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 48) send_cmd(FUNC_FILL, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 56) send_cmd(FUNC_SCALE, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 82) send_cmd(FUNC_REFRESH, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 93) send_tick();
                    else if (pick < 98)
                        send_cmd(3'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7)),
                                 idx, rnd8(), rnd8(), rnd8(), br);
                    else cfg_write(CFG_PIXEL_COUNT, 16'($urandom_range(0, 3)));
                end else begin
                    if (pick < 85) send_tick();
                    else if (pick < 89) send_cmd(FUNC_WRITE, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 91) send_cmd(FUNC_FILL, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 93) send_cmd(FUNC_SCALE, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 96) send_cmd(FUNC_REFRESH, idx, rnd8(), rnd8(), rnd8(), br);
                    else if (pick < 98)
                        send_cmd(3'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7)),
                                 idx, rnd8(), rnd8(), rnd8(), br);
                    else cfg_write(3'($urandom_range(CFG_ZERO_HIGH, CFG_LATCH)),
                                   16'($urandom_range(0, 3)));
                end
            end
            run_frame();
        end
    endtask

    task automatic test_long_frames();
        idle_on = 1'b0;
        program_timing(9'h1ff, 8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
        send_cmd(FUNC_FILL, 8'd0, 8'h5a, 8'hc3, 8'h81, 8'h00);
        send_cmd(FUNC_WRITE, 8'd255, 8'hff, 8'h00, 8'hff, 8'hff);
        send_cmd(FUNC_WRITE, 8'd0, 8'hff, 8'hff, 8'hff, 8'h00);
        send_cmd(FUNC_SCALE, 8'd0, 8'h00, 8'h00, 8'h00, 8'hfe);
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_frame();
        cfg_write(CFG_PIXEL_COUNT, 16'd256);
        send_cmd(FUNC_WRITE, 8'd255, 8'h12, 8'h34, 8'h56, 8'hff);
        send_cmd(FUNC_SCALE, 8'd0, 8'h00, 8'h00, 8'h00, 8'h7f);
        program_timing(9'd1, 8'd255, 8'd255, 8'd255, 8'd255, 16'hffff);
        send_cmd(FUNC_WRITE, 8'd0, 8'ha5, 8'h3c, 8'hf0, 8'hff);
        send_cmd(FUNC_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_frame();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_frame();
        test_commands();
        test_zero_registers();
        test_live_changes();
        test_random_traffic();
        test_long_frames();
        settle();
        repeat (50) @(posedge i_clk);
        if (bad_results == 0 && due_results.size() == 0) begin
            $display("led_strip_pixel_serializer_top verification clean");
        end else begin
            $display("led_strip_pixel_serializer_top verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("led_strip_pixel_serializer_top verification failed");
        $finish;
    end

endmodule
